@@ hdl/ptpr_pkg.sv @@
// Shared types and constants for the point table with proximity remove.
// No dependencies; ptpr_ctrl, ptpr_dp and the top module import this package.
`timescale 1ns / 1ps
`default_nettype none

package ptpr_pkg;

  localparam int COORD_W  = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int FILL_W   = 5;
  localparam int CFG_IDX_W = 2;

  // Item command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_VACUUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEDUP  = 2'd1;
  localparam logic [COORD_W-1:0] VACUUM_RESET = 16'd10;
  localparam logic [COORD_W-1:0] DEDUP_RESET  = 16'd0;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] weight;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [FILL_W-1:0]   fill_count;
  } out_beat_t;

  // One table entry as held in the RAM
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] weight;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_load;
    logic shift;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic remove;
    logic match;
    logic scan_none;
    logic shift_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

@@ hdl/ptpr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptpr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/ptpr_ctrl.sv @@
// Sequencer for the point table: accept, scan, shift on removal, finish.
// Depends on ptpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptpr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ptpr_pkg::ctrl_stat_t stat,
  output ptpr_pkg::ctrl_cmd_t       cmd
);

  import ptpr_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.match) begin
          state_next = stat.remove ? S_SHIFT : S_FIN;
        end else if (stat.scan_none || stat.empty) begin
          state_next = S_FIN;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.scan       = 1'b1;
        cmd.shift_load = stat.match && stat.remove;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
      end
      S_FIN: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ptpr_dp.sv @@
// Datapath: item and radius registers, entry count, table RAM with scan and
// shift pointers, proximity compare and the result register.
// Depends on ptpr_pkg and ptpr_ram.
`timescale 1ns / 1ps
`default_nettype none

module ptpr_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ptpr_pkg::ctrl_cmd_t              cmd,
  output ptpr_pkg::ctrl_stat_t                  stat,
  input  wire ptpr_pkg::in_beat_t               in_data,
  input  wire logic                             cfg_we,
  input  wire logic [ptpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ptpr_pkg::COORD_W-1:0]     cfg_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output ptpr_pkg::out_beat_t                   out_data
);

  import ptpr_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  in_beat_t           item;
  logic [COORD_W-1:0] vacuum_radius;
  logic [COORD_W-1:0] dedup_radius;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   rd_ptr;
  logic               pipe_valid;
  logic [IDX_W-1:0]   pipe_idx;
  logic               found;
  logic [IDX_W-1:0]   hit_idx;

  logic               issue;
  logic [COORD_W-1:0] radius;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic               near;
  logic               insert_ok;
  entry_t             rdata;
  entry_t             wdata;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [IDX_W-1:0]   raddr;
  out_beat_t          result;
  logic [31:0]        slot_wide;
  logic [31:0]        fill_wide;

  // Table storage
  ptpr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read issue: one entry a cycle during a scan or shift while the pointer is below the count
  assign issue = (cmd.scan || cmd.shift) && (rd_ptr < count);
  assign raddr = rd_ptr[IDX_W-1:0];

  // Proximity compare on the entry read last cycle
  assign radius = (item.cmd == CMD_REMOVE) ? vacuum_radius : dedup_radius;
  assign dx = (rdata.x >= item.pos_x) ? rdata.x - item.pos_x : item.pos_x - rdata.x;
  assign dy = (rdata.y >= item.pos_y) ? rdata.y - item.pos_y : item.pos_y - rdata.y;
  assign near = (dx <= radius) && (dy <= radius);

  assign insert_ok = (item.cmd == CMD_INSERT) && !found && (count < DEPTH_C);

  // Status back to the controller
  always_comb begin
    stat            = '0;
    stat.empty      = (count == '0);
    stat.remove     = (item.cmd == CMD_REMOVE);
    stat.match      = cmd.scan && pipe_valid && near;
    stat.scan_none  = pipe_valid && !near && ((CNT_W'(pipe_idx) + CNT_W'(1)) == count);
    stat.shift_done = !pipe_valid && !(rd_ptr < count);
    stat.out_free   = !out_valid || out_ready;
  end

  // Write port: shift copies entry i+1 to i; finish appends an insert
  always_comb begin
    we    = 1'b0;
    waddr = pipe_idx;
    wdata = rdata;
    if (cmd.shift) begin
      we = pipe_valid;
    end else if (cmd.finish) begin
      we           = insert_ok;
      waddr        = count[IDX_W-1:0];
      wdata.x      = item.pos_x;
      wdata.y      = item.pos_y;
      wdata.weight = item.weight;
    end
  end

  // Result and new count
  always_comb begin
    count_next    = count;
    result.status = ST_NONE;
    slot_wide     = '0;
    if (item.cmd == CMD_INSERT) begin
      if (found) begin
        result.status = ST_DUPLICATE;
        slot_wide     = 32'(hit_idx);
      end else if (insert_ok) begin
        result.status = ST_INSERTED;
        slot_wide     = 32'(count);
        count_next    = count + CNT_W'(1);
      end else begin
        result.status = ST_FULL;
      end
    end else if (found) begin
      result.status = ST_REMOVED;
      slot_wide     = 32'(hit_idx);
      count_next    = count - CNT_W'(1);
    end
    fill_wide         = 32'(count_next);
    result.slot       = slot_wide[SLOT_W-1:0];
    result.fill_count = fill_wide[FILL_W-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      rd_ptr        <= '0;
      pipe_valid    <= 1'b0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
      vacuum_radius <= VACUUM_RESET;
      dedup_radius  <= DEDUP_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VACUUM: vacuum_radius <= cfg_data;
          CFG_DEDUP:  dedup_radius  <= cfg_data;
          default:    ;
        endcase
      end

      if (cmd.load) begin
        rd_ptr <= '0;
      end else if (cmd.shift_load) begin
        rd_ptr <= CNT_W'(pipe_idx) + CNT_W'(1);
      end else if (issue) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end

      pipe_valid <= issue && !cmd.load && !cmd.shift_load;

      if (cmd.load) begin
        found <= 1'b0;
      end else if (stat.match) begin
        found <= 1'b1;
      end

      if (cmd.finish) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    // in a shift the pipe index names the write target, one below the read
    if (cmd.shift) begin
      pipe_idx <= IDX_W'(rd_ptr - CNT_W'(1));
    end else begin
      pipe_idx <= rd_ptr[IDX_W-1:0];
    end
    if (stat.match) begin
      hit_idx <= pipe_idx;
    end
    if (cmd.finish) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ hdl/point_table_proximity_remove_top.sv @@
// Point table with proximity dedup on insert and proximity remove.
// Steps: accept, scan the valid entries up to the first match, on a removal
// shift every later entry down one slot, then finish (held while an earlier
// result beat is unread). Scan and shift read the table RAM one entry a
// cycle. One item is worked at a time. Reset empties the table (count to
// zero), sets the radii to 10 and 0; table contents are not cleared.
// Depends on ptpr_pkg, ptpr_ctrl, ptpr_dp and ptpr_ram.
`timescale 1ns / 1ps
`default_nettype none

module point_table_proximity_remove_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ptpr_pkg::in_beat_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ptpr_pkg::out_beat_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ptpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptpr_pkg::COORD_W-1:0]   cfg_data
);

  import ptpr_pkg::*;

  ctrl_cmd_t  ctl_cmd;
  ctrl_stat_t ctl_stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  ptpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (ctl_stat),
    .cmd      (ctl_cmd)
  );

  ptpr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl_cmd),
    .stat      (ctl_stat),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // One item in flight: no second beat straight after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Dropped inserts and failed removes report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_FULL || out_data.status == ST_NONE)
      |-> out_data.slot == '0)
    else $error("non-zero slot on a miss");

  // An append lands at the old end of the table
  a_append: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_INSERTED
      |-> out_data.fill_count[3:0] == out_data.slot + 4'd1)
    else $error("inserted slot does not match new fill count");

  // Shifting only ever follows a remove
  a_shift_remove: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.shift |-> ctl_stat.remove)
    else $error("shift on an insert");

endmodule

`default_nettype wire
